// ===== rtl/core/rcm_pkg.sv =====
// ============================================================================
// RGBA color matrix package
// Shared widths, register indexes and beat/stage payload types.
// ============================================================================
`default_nettype none

package rcm_pkg;

  // Pixel and coefficient geometry
  localparam int NUM_CH             = 4;
  localparam int PIX_W              = 8;
  localparam int LANE_W             = 16;
  localparam int ROW_W              = NUM_CH * LANE_W;
  localparam int CFG_IDX_W          = 3;
  localparam int COEF_FRAC_BITS_DEF = 12;

  // Datapath widths: signed product, partial sum, full accumulator
  localparam int PROD_W = LANE_W + PIX_W;
  localparam int PSUM_W = PROD_W + 2;
  localparam int ACC_W  = PROD_W + 3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_ROW    = 3'd0,
    REG_GREEN_ROW  = 3'd1,
    REG_BLUE_ROW   = 3'd2,
    REG_ALPHA_ROW  = 3'd3,
    REG_OFFSET_ROW = 3'd4
  } rcm_reg_t;

  // One register: four 16-bit two's complement lanes, lane k at bits 16k+15..16k
  typedef logic [NUM_CH-1:0][LANE_W-1:0] rcm_row_t;

  typedef struct packed {
    rcm_row_t [NUM_CH-1:0] coef;    // coef[out channel][in channel]
    rcm_row_t              offset;  // offset[out channel]
  } rcm_matrix_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_in;
    logic [PIX_W-1:0] green_in;
    logic [PIX_W-1:0] blue_in;
    logic [PIX_W-1:0] alpha_in;
    logic             frame_end_in;
  } rcm_in_t;

  typedef struct packed {
    logic [PIX_W-1:0] red_out;
    logic [PIX_W-1:0] green_out;
    logic [PIX_W-1:0] blue_out;
    logic [PIX_W-1:0] alpha_out;
    logic             frame_end_out;
  } rcm_out_t;

  // Stage 1 result: all products and scaled offsets
  typedef struct packed {
    logic [NUM_CH-1:0][NUM_CH-1:0][PROD_W-1:0] prod;
    logic [NUM_CH-1:0][PROD_W-1:0]             offs;
    logic                                      frame_end;
  } rcm_prod_t;

  // Stage 2 result: two partial sums per output channel
  typedef struct packed {
    logic [NUM_CH-1:0][PSUM_W-1:0] sum_a;
    logic [NUM_CH-1:0][PSUM_W-1:0] sum_b;
    logic                          frame_end;
  } rcm_psum_t;

endpackage

`default_nettype wire

// ===== rtl/core/rgba_color_matrix.sv =====
// ============================================================================
// RGBA color matrix
// 4x5 signed Q-format color matrix applied to one RGBA8 pixel per clock while not stalled.
// ============================================================================
// A pixel beat enters while in_stall is low and passes through registered
// stages (multiply, partial sum, final sum with saturate), one pixel per clock
// sustained. Each stage holds its own valid bit, so out_stall pushes back one
// stage at a time and in_stall rises only when all three stages hold a beat
// and the output is stalled. The five matrix rows are written on the cfg
// channel, which always shows cfg_ready; rows must be written only while no
// pixel is in flight. Reset loads the identity matrix with zero offsets.
`default_nettype none

module rgba_color_matrix
  import rcm_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire rcm_in_t              in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output rcm_out_t                  out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ROW_W-1:0]     cfg_data
);

  rcm_matrix_t matrix;
  logic        mul_ready;
  logic        mul_valid;
  rcm_prod_t   mul_data;
  logic        add_ready;
  logic        add_valid;
  rcm_psum_t   add_data;
  logic        sat_ready;

  // Matrix rows
  rcm_cfg_regs #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .matrix    (matrix)
  );

  // Stage 1: products
  rcm_mul_stage u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (in_valid),
    .ready_in  (mul_ready),
    .data_in   (in_data),
    .matrix    (matrix),
    .valid_r   (mul_valid),
    .ready_out (add_ready),
    .data_r    (mul_data)
  );

  // Stage 2: partial sums
  rcm_add_stage u_add (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (mul_valid),
    .ready_in  (add_ready),
    .data_in   (mul_data),
    .valid_r   (add_valid),
    .ready_out (sat_ready),
    .data_r    (add_data)
  );

  // Stage 3: final sum and saturate into the output register
  rcm_sat_stage #(
    .COEF_FRAC_BITS(COEF_FRAC_BITS)
  ) u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (add_valid),
    .ready_in  (sat_ready),
    .data_in   (add_data),
    .valid_r   (out_valid),
    .ready_out (!out_stall),
    .data_r    (out_data)
  );

  assign in_stall = !mul_ready;

`ifndef SYNTHESIS
  // Input backs up only when every stage is full and the output is stalled
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (mul_valid && add_valid && out_valid && out_stall))
    else $error("in_stall does not match pipeline occupancy");

  // Beats in flight change only by accepted input and output beats
  assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |->
      ($countones({mul_valid, add_valid, out_valid})
        == $past($countones({mul_valid, add_valid, out_valid}))
         + $past(in_valid && !in_stall) - $past(out_valid && !out_stall)))
    else $error("pixel beat lost or duplicated in pipeline");

  // A full stage waiting on a stalled successor keeps its beat
  assert property (@(posedge clk) disable iff (!rst_n)
    (add_valid && out_valid && out_stall) |=> add_valid)
    else $error("stage 2 beat dropped while output stalled");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/rcm_cfg_regs.sv =====
// ============================================================================
// RGBA color matrix configuration registers
// Five 64-bit rows written over the cfg channel; reset to the identity.
// ============================================================================
`default_nettype none

module rcm_cfg_regs
  import rcm_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ROW_W-1:0]     cfg_data,
  output rcm_matrix_t               matrix
);

  localparam logic [LANE_W-1:0] COEF_ONE = LANE_W'(1 << COEF_FRAC_BITS);

  // Identity rows: unity in the lane of the row's own channel
  localparam rcm_row_t RED_RESET   = {{3*LANE_W{1'b0}}, COEF_ONE};
  localparam rcm_row_t GREEN_RESET = {{2*LANE_W{1'b0}}, COEF_ONE, {LANE_W{1'b0}}};
  localparam rcm_row_t BLUE_RESET  = {{LANE_W{1'b0}}, COEF_ONE, {2*LANE_W{1'b0}}};
  localparam rcm_row_t ALPHA_RESET = {COEF_ONE, {3*LANE_W{1'b0}}};

  rcm_row_t red_row_r,    red_row_nxt;
  rcm_row_t green_row_r,  green_row_nxt;
  rcm_row_t blue_row_r,   blue_row_nxt;
  rcm_row_t alpha_row_r,  alpha_row_nxt;
  rcm_row_t offset_row_r, offset_row_nxt;

  // Always able to take a write beat
  assign cfg_ready = 1'b1;

  // Decode the write; drop indexes beyond the register list
  always_comb begin
    red_row_nxt    = red_row_r;
    green_row_nxt  = green_row_r;
    blue_row_nxt   = blue_row_r;
    alpha_row_nxt  = alpha_row_r;
    offset_row_nxt = offset_row_r;
    if (cfg_valid && cfg_ready) begin
      case (rcm_reg_t'(cfg_index))
        REG_RED_ROW:    red_row_nxt    = cfg_data;
        REG_GREEN_ROW:  green_row_nxt  = cfg_data;
        REG_BLUE_ROW:   blue_row_nxt   = cfg_data;
        REG_ALPHA_ROW:  alpha_row_nxt  = cfg_data;
        REG_OFFSET_ROW: offset_row_nxt = cfg_data;
        default: ;
      endcase
    end
  end

  // Hold rows; reset to unity on the diagonal and zero offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_row_r    <= RED_RESET;
      green_row_r  <= GREEN_RESET;
      blue_row_r   <= BLUE_RESET;
      alpha_row_r  <= ALPHA_RESET;
      offset_row_r <= '0;
    end else begin
      red_row_r    <= red_row_nxt;
      green_row_r  <= green_row_nxt;
      blue_row_r   <= blue_row_nxt;
      alpha_row_r  <= alpha_row_nxt;
      offset_row_r <= offset_row_nxt;
    end
  end

  assign matrix.coef[0] = red_row_r;
  assign matrix.coef[1] = green_row_r;
  assign matrix.coef[2] = blue_row_r;
  assign matrix.coef[3] = alpha_row_r;
  assign matrix.offset  = offset_row_r;

endmodule

`default_nettype wire

// ===== rtl/core/rcm_mul_stage.sv =====
// ============================================================================
// RGBA color matrix multiply stage
// Forms all sixteen coefficient-times-channel products and four offsets x 255.
// ============================================================================
`default_nettype none

module rcm_mul_stage
  import rcm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        valid_in,
  output logic             ready_in,
  input  wire rcm_in_t     data_in,
  input  wire rcm_matrix_t matrix,
  output logic             valid_r,
  input  wire logic        ready_out,
  output rcm_prod_t        data_r
);

  logic [NUM_CH-1:0][PIX_W-1:0] pix;
  logic signed [PROD_W:0]       full_prod [NUM_CH][NUM_CH];
  logic signed [PROD_W:0]       full_offs [NUM_CH];
  rcm_prod_t                    data_nxt;

  assign pix[0] = data_in.red_in;
  assign pix[1] = data_in.green_in;
  assign pix[2] = data_in.blue_in;
  assign pix[3] = data_in.alpha_in;

  // Signed coefficient times zero-extended channel; offset x 255 as x256 - x1
  always_comb begin
    for (int j = 0; j < NUM_CH; j++) begin
      for (int k = 0; k < NUM_CH; k++) begin
        full_prod[j][k] = $signed(matrix.coef[j][k]) * $signed({1'b0, pix[k]});
        data_nxt.prod[j][k] = full_prod[j][k][PROD_W-1:0];
      end
      full_offs[j] = (PROD_W+1)'($signed({matrix.offset[j], {PIX_W{1'b0}}}))
                   - (PROD_W+1)'($signed(matrix.offset[j]));
      data_nxt.offs[j] = full_offs[j][PROD_W-1:0];
    end
    data_nxt.frame_end = data_in.frame_end_in;
  end

  // Advance when empty or when the next stage takes our beat
  assign ready_in = !valid_r || ready_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rcm_add_stage.sv =====
// ============================================================================
// RGBA color matrix partial-sum stage
// Reduces five terms per output channel to two partial sums.
// ============================================================================
`default_nettype none

module rcm_add_stage
  import rcm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      valid_in,
  output logic           ready_in,
  input  wire rcm_prod_t data_in,
  output logic           valid_r,
  input  wire logic      ready_out,
  output rcm_psum_t      data_r
);

  rcm_psum_t data_nxt;

  // Red and green products with the offset; blue and alpha products
  always_comb begin
    for (int j = 0; j < NUM_CH; j++) begin
      data_nxt.sum_a[j] = PSUM_W'($signed(data_in.prod[j][0]))
                        + PSUM_W'($signed(data_in.prod[j][1]))
                        + PSUM_W'($signed(data_in.offs[j]));
      data_nxt.sum_b[j] = PSUM_W'($signed(data_in.prod[j][2]))
                        + PSUM_W'($signed(data_in.prod[j][3]));
    end
    data_nxt.frame_end = data_in.frame_end;
  end

  assign ready_in = !valid_r || ready_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rcm_sat_stage.sv =====
// ============================================================================
// RGBA color matrix final-sum and saturate stage
// Adds the partial sums, floors by the fraction width and clamps to 0..255.
// ============================================================================
`default_nettype none

module rcm_sat_stage
  import rcm_pkg::*;
#(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      valid_in,
  output logic           ready_in,
  input  wire rcm_psum_t data_in,
  output logic           valid_r,
  input  wire logic      ready_out,
  output rcm_out_t       data_r
);

  localparam logic [PIX_W-1:0] PIX_MAX = {PIX_W{1'b1}};

  logic [NUM_CH-1:0][ACC_W-1:0] acc;
  logic [NUM_CH-1:0][ACC_W-1:0] shifted;
  logic [NUM_CH-1:0][PIX_W-1:0] chan;
  rcm_out_t                     data_nxt;

  // Negative clamps to zero; a floored value above the pixel range clamps high
  always_comb begin
    for (int j = 0; j < NUM_CH; j++) begin
      acc[j]     = ACC_W'($signed(data_in.sum_a[j])) + ACC_W'($signed(data_in.sum_b[j]));
      shifted[j] = acc[j] >> COEF_FRAC_BITS;
      if (acc[j][ACC_W-1]) begin
        chan[j] = '0;
      end else if (|shifted[j][ACC_W-1:PIX_W]) begin
        chan[j] = PIX_MAX;
      end else begin
        chan[j] = shifted[j][PIX_W-1:0];
      end
    end
    data_nxt.red_out       = chan[0];
    data_nxt.green_out     = chan[1];
    data_nxt.blue_out      = chan[2];
    data_nxt.alpha_out     = chan[3];
    data_nxt.frame_end_out = data_in.frame_end;
  end

  assign ready_in = !valid_r || ready_out;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_in) begin
      valid_r <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_in && valid_in) begin
      data_r <= data_nxt;
    end
  end

endmodule

`default_nettype wire
